// File: design/eps_pkg.sv
// ----------------------------------------------------------------------------
// Exposure phase sequencer package
// Shared types, codes and constants of the exposure phase sequencer.
// ----------------------------------------------------------------------------
package eps_pkg;

   localparam int MAX_MUX_LINES_DEFAULT = 8;
   localparam int MUX_INDEX_WIDTH       = 3;
   localparam int MUX_INDEX_RANGE       = 2 ** MUX_INDEX_WIDTH;

   localparam int COUNT_WIDTH   = 16;
   localparam int TIME_WIDTH    = 26;
   localparam int PERCENT_WIDTH = 7;
   localparam int PHASES_WIDTH  = 17;
   localparam int POLL_WIDTH    = 10;
   localparam int LINES_WIDTH   = 4;
   localparam int LEVEL_WIDTH   = 12;
   localparam int WORD_WIDTH    = 13;

   localparam int REQ_DATA_WIDTH = 88;
   localparam int RSP_DATA_WIDTH = 56;
   localparam int CSR_DATA_WIDTH = 10;

   localparam logic [TIME_WIDTH-1:0]    MAX_TIME_MS  = 26'd64800000;
   localparam logic [TIME_WIDTH-1:0]    ELAPSED_MAX  = 26'h3FFFFFF;
   localparam logic [POLL_WIDTH-1:0]    POLL_MAX     = 10'h3FF;
   localparam logic [PERCENT_WIDTH-1:0] MAX_PERCENT  = 7'd100;
   localparam int                       DAC_FULL     = 4095;
   localparam int                       PERCENT_FULL = 100;

   localparam logic [POLL_WIDTH-1:0]  POLL_INTERVAL_RESET = 10'd100;
   localparam logic [LINES_WIDTH-1:0] MUX_LINES_RESET     = 4'd8;

   typedef enum logic [1:0] {
      CMD_TICK      = 2'd0,
      CMD_START     = 2'd1,
      CMD_INTERRUPT = 2'd2
   } eps_cmd_type;

   typedef enum logic [1:0] {
      REPORT_NONE        = 2'd0,
      REPORT_ENDED       = 2'd1,
      REPORT_INTERRUPTED = 2'd2
   } eps_report_type;

   typedef enum logic [0:0] {
      CSR_POLL_INTERVAL = 1'd0,
      CSR_MUX_LINES     = 1'd1
   } eps_csr_type;

   typedef struct packed {
      logic [1:0]               cmd;
      logic [COUNT_WIDTH-1:0]   cycle_count;
      logic [TIME_WIDTH-1:0]    exposure_ms;
      logic [TIME_WIDTH-1:0]    pause_ms;
      logic [PERCENT_WIDTH-1:0] led_percent;
      logic [PERCENT_WIDTH-1:0] ring_percent;
   } eps_item_type;

   typedef struct packed {
      logic                       dac_write;
      logic [WORD_WIDTH-1:0]      led_word;
      logic [WORD_WIDTH-1:0]      ring_word;
      logic                       lamp_enabled;
      logic [1:0]                 report;
      logic                       poll_sensors;
      logic                       sample_voltages;
      logic [MUX_INDEX_WIDTH-1:0] mux_select;
      logic [PHASES_WIDTH-1:0]    phases_left;
   } eps_result_type;

   typedef struct packed {
      logic [PHASES_WIDTH-1:0]    phases_remaining;
      logic [TIME_WIDTH-1:0]      stored_exposure_ms;
      logic [TIME_WIDTH-1:0]      stored_pause_ms;
      logic [PERCENT_WIDTH-1:0]   stored_led_percent;
      logic [PERCENT_WIDTH-1:0]   stored_ring_percent;
      logic [TIME_WIDTH-1:0]      phase_length_ms;
      logic [TIME_WIDTH-1:0]      phase_elapsed;
      logic [POLL_WIDTH-1:0]      poll_elapsed;
      logic [MUX_INDEX_WIDTH-1:0] mux_index;
   } eps_state_type;

   typedef logic [LEVEL_WIDTH-1:0] level_table_type [2**PERCENT_WIDTH];

   function automatic level_table_type build_level_table();
      level_table_type t;
      for (int i = 0; i < 2**PERCENT_WIDTH; i++) begin
         t[i] = LEVEL_WIDTH'((i * DAC_FULL) / PERCENT_FULL);
      end
      return t;
   endfunction

   // DAC level for each power percent, truncated.
   localparam level_table_type LEVEL_TABLE = build_level_table();

endpackage

// File: design/eps_step.sv
// ----------------------------------------------------------------------------
// Exposure phase sequencer step logic
// Next state and result of one transaction from the current sequencer state.
// ----------------------------------------------------------------------------
module eps_step #(
   parameter int MAX_MUX_LINES = eps_pkg::MAX_MUX_LINES_DEFAULT
) (
   input  eps_pkg::eps_state_type                 state_cur,
   input  eps_pkg::eps_item_type                  item,
   input  logic [eps_pkg::POLL_WIDTH-1:0]         poll_interval,
   input  logic [eps_pkg::LINES_WIDTH-1:0]        mux_lines,
   output eps_pkg::eps_state_type                 state_nxt,
   output eps_pkg::eps_result_type                result
);

   logic [eps_pkg::LINES_WIDTH-1:0]     line_count;
   logic [eps_pkg::MUX_INDEX_WIDTH-1:0] mux_next;

   always_comb begin
      logic [eps_pkg::LINES_WIDTH-1:0] v;
      if (mux_lines == '0) begin
         line_count = eps_pkg::LINES_WIDTH'(1);
      end else if (mux_lines > eps_pkg::LINES_WIDTH'(MAX_MUX_LINES)) begin
         line_count = eps_pkg::LINES_WIDTH'(MAX_MUX_LINES);
      end else begin
         line_count = mux_lines;
      end
      v = {1'b0, state_cur.mux_index} + eps_pkg::LINES_WIDTH'(1);
      for (int i = 0; i < eps_pkg::MUX_INDEX_RANGE; i++) begin
         if (v >= line_count) begin
            v = v - line_count;
         end
      end
      mux_next = v[eps_pkg::MUX_INDEX_WIDTH-1:0];
   end

   always_comb begin
      logic [eps_pkg::TIME_WIDTH-1:0]    elapsed;
      logic [eps_pkg::POLL_WIDTH-1:0]    polled;
      logic                              do_send;
      logic                              do_stop;
      logic [1:0]                        stop_code;
      logic [eps_pkg::TIME_WIDTH-1:0]    send_time;
      logic [eps_pkg::PERCENT_WIDTH-1:0] send_led;
      logic [eps_pkg::PERCENT_WIDTH-1:0] send_ring;

      state_nxt = state_cur;
      result    = '0;
      do_send   = 1'b0;
      do_stop   = 1'b0;
      stop_code = eps_pkg::REPORT_NONE;
      send_time = state_cur.stored_exposure_ms;
      send_led  = state_cur.stored_led_percent;
      send_ring = state_cur.stored_ring_percent;
      elapsed   = (state_cur.phase_elapsed < eps_pkg::ELAPSED_MAX)
                  ? state_cur.phase_elapsed + eps_pkg::TIME_WIDTH'(1)
                  : state_cur.phase_elapsed;
      polled    = (state_cur.poll_elapsed < eps_pkg::POLL_MAX)
                  ? state_cur.poll_elapsed + eps_pkg::POLL_WIDTH'(1)
                  : state_cur.poll_elapsed;

      unique case (item.cmd)
         eps_pkg::CMD_TICK: begin
            state_nxt.phase_elapsed = elapsed;
            if (state_cur.phases_remaining != '0 && elapsed >= state_cur.phase_length_ms) begin
               state_nxt.phases_remaining =
                  state_cur.phases_remaining - eps_pkg::PHASES_WIDTH'(1);
               state_nxt.phase_elapsed = '0;
               if (state_nxt.phases_remaining == '0) begin
                  do_stop   = 1'b1;
                  stop_code = eps_pkg::REPORT_ENDED;
               end else if (!state_nxt.phases_remaining[0]) begin
                  do_send = 1'b1;
               end else begin
                  do_send   = 1'b1;
                  send_time = state_cur.stored_pause_ms;
                  send_led  = '0;
                  send_ring = '0;
               end
            end
            if (state_nxt.phases_remaining != '0) begin
               state_nxt.poll_elapsed = polled;
               if (polled >= poll_interval) begin
                  result.poll_sensors    = 1'b1;
                  result.sample_voltages = !state_nxt.phases_remaining[0];
                  state_nxt.mux_index    = mux_next;
                  state_nxt.poll_elapsed = '0;
               end
            end
         end
         eps_pkg::CMD_START: begin
            state_nxt.mux_index = '0;
            if (item.cycle_count != '0) begin
               state_nxt.stored_exposure_ms  = item.exposure_ms;
               state_nxt.stored_pause_ms     = item.pause_ms;
               state_nxt.stored_led_percent  = item.led_percent;
               state_nxt.stored_ring_percent = item.ring_percent;
               state_nxt.phases_remaining    = {item.cycle_count, 1'b0};
               state_nxt.phase_elapsed       = '0;
               state_nxt.poll_elapsed        = '0;
               do_send   = 1'b1;
               send_time = item.exposure_ms;
               send_led  = item.led_percent;
               send_ring = item.ring_percent;
            end
         end
         eps_pkg::CMD_INTERRUPT: begin
            if (state_cur.phases_remaining != '0) begin
               do_stop   = 1'b1;
               stop_code = eps_pkg::REPORT_INTERRUPTED;
            end
         end
         default: begin
         end
      endcase

      if (do_send && send_time <= eps_pkg::MAX_TIME_MS && send_led <= eps_pkg::MAX_PERCENT
          && send_ring <= eps_pkg::MAX_PERCENT) begin
         state_nxt.phase_length_ms = send_time;
         result.dac_write = 1'b1;
         result.led_word  = {1'b1, eps_pkg::LEVEL_TABLE[send_led]};
         result.ring_word = {1'b1, eps_pkg::LEVEL_TABLE[send_ring]};
      end

      if (do_stop) begin
         state_nxt.phases_remaining    = '0;
         state_nxt.stored_exposure_ms  = '0;
         state_nxt.stored_pause_ms     = '0;
         state_nxt.stored_led_percent  = '0;
         state_nxt.stored_ring_percent = '0;
         state_nxt.phase_length_ms     = '0;
         result.dac_write = 1'b1;
         result.led_word  = '0;
         result.ring_word = '0;
         result.report    = stop_code;
      end

      result.lamp_enabled = (state_nxt.phases_remaining != '0);
      result.mux_select   = state_nxt.mux_index;
      result.phases_left  = state_nxt.phases_remaining;
   end

endmodule

// File: design/exposure_phase_sequencer.sv
// ----------------------------------------------------------------------------
// Exposure phase sequencer
// Millisecond-tick driven exposure lamp sequencer with DAC phase words,
// run reports and feedback poll requests.
// ----------------------------------------------------------------------------
// The sequencer takes one transaction per clock while rsp_tready does not
// stall it, and returns exactly one result transaction for each, in order.
// A transaction passes through an input register and the step logic into
// the result register; all state updates in the same clock as the result
// register loads, which lets the next request follow at once.
// Configuration writes are taken at any time and are meant for idle periods.
module exposure_phase_sequencer #(
   parameter int MAX_MUX_LINES = eps_pkg::MAX_MUX_LINES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // cycle_count, exposure_ms, pause_ms, led_percent, ring_percent
   input  logic [eps_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // cmd
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // led_word, ring_word, lamp_enabled, report, poll_sensors,
   // sample_voltages, mux_select, phases_left
   output logic [eps_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   // dac_write
   output logic                                rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [0:0]                          csr_index,
   input  logic [eps_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic                             in_valid_ff;
   eps_pkg::eps_item_type            in_item_ff;
   eps_pkg::eps_item_type            in_item_in;
   eps_pkg::eps_state_type           state_ff;
   eps_pkg::eps_state_type           state_in;
   eps_pkg::eps_result_type          rsp_data_ff;
   eps_pkg::eps_result_type          rsp_data_in;
   logic                             rsp_valid_ff;
   logic [eps_pkg::POLL_WIDTH-1:0]   poll_interval_ff;
   logic [eps_pkg::LINES_WIDTH-1:0]  mux_lines_ff;
   logic                             advance;
   logic                             req_accept;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign in_item_in.cmd          = req_tuser;
   assign in_item_in.cycle_count  = req_tdata[15:0];
   assign in_item_in.exposure_ms  = req_tdata[41:16];
   assign in_item_in.pause_ms     = req_tdata[67:42];
   assign in_item_in.led_percent  = req_tdata[74:68];
   assign in_item_in.ring_percent = req_tdata[81:75];

   eps_step #(
      .MAX_MUX_LINES(MAX_MUX_LINES)
   ) u_step (
      .state_cur    (state_ff),
      .item         (in_item_ff),
      .poll_interval(poll_interval_ff),
      .mux_lines    (mux_lines_ff),
      .state_nxt    (state_in),
      .result       (rsp_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         state_ff         <= '0;
         poll_interval_ff <= eps_pkg::POLL_INTERVAL_RESET;
         mux_lines_ff     <= eps_pkg::MUX_LINES_RESET;
      end else begin
         if (req_accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               eps_pkg::CSR_POLL_INTERVAL: poll_interval_ff <= csr_wdata;
               eps_pkg::CSR_MUX_LINES:     mux_lines_ff <= csr_wdata[eps_pkg::LINES_WIDTH-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= in_item_in;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.dac_write;
   assign rsp_tdata  = {5'd0,
                        rsp_data_ff.phases_left,
                        rsp_data_ff.mux_select,
                        rsp_data_ff.sample_voltages,
                        rsp_data_ff.poll_sensors,
                        rsp_data_ff.report,
                        rsp_data_ff.lamp_enabled,
                        rsp_data_ff.ring_word,
                        rsp_data_ff.led_word};

   // The lamp is on exactly while phases remain.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.lamp_enabled == (rsp_data_ff.phases_left != '0)))
      else $error("lamp enable disagrees with remaining phases");

   // A report always comes with zeroed DAC words and an ended run.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.report != eps_pkg::REPORT_NONE) |->
      (rsp_data_ff.dac_write && rsp_data_ff.led_word == '0 && rsp_data_ff.ring_word == '0
       && rsp_data_ff.phases_left == '0))
      else $error("report without a stopping DAC write");

   // Voltage sampling is only requested together with a poll.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.sample_voltages) |-> rsp_data_ff.poll_sensors)
      else $error("voltage sampling without a poll");

   // A held request must not be overwritten by a new one.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |-> !req_tready)
      else $error("input register accepts while holding a transaction");

endmodule
